// ----- src/olist_pkg.sv -----
// ============================================================================
// olist_pkg: shared types and codes for the ordered list engine
// Action and status codes, cell operation codes and the control word that
// the sequencer broadcasts to every cell of the chain.
// ============================================================================
package olist_pkg;

    // Field widths fixed by the interface.
    localparam int ACT_W  = 3;
    localparam int IDX_W  = 7;
    localparam int STAT_W = 2;
    localparam int PORT_W = 32;

    // Widest position inside the chain (up to 64 cells).
    localparam int POS_W = 6;

    // Actions carried by an input transfer.
    localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ERASE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DUMP_FWD = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DUMP_REV = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // Search position reported when there is no match.
    localparam logic [IDX_W-1:0] FOUND_NONE = 7'h7F;

    // Cell operations.
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op OP_HOLD     = 2'd0;
    localparam t_cell_op OP_SHR      = 2'd1;
    localparam t_cell_op OP_SHL      = 2'd2;
    localparam t_cell_op OP_COLLAPSE = 2'd3;

    // Control word shared by all cells.
    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] k;
    } t_cell_ctl;

endpackage

// ----- src/olist_cell.sv -----
// ============================================================================
// olist_cell: one storage cell of the list chain
// Holds one entry and, on command, takes the entry of its left or right
// neighbour. A collapse moves only the cells at or beyond the given position.
// ============================================================================
module olist_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  olist_pkg::t_cell_ctl  i_ctl,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_beyond;

    // This cell lies at or past the position being removed.
    assign w_beyond = (olist_pkg::POS_W'(INDEX) >= i_ctl.k);

    // Select the next entry from the neighbours.
    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            olist_pkg::OP_HOLD:     n_data = r_data;
            olist_pkg::OP_SHR:      n_data = i_left;
            olist_pkg::OP_SHL:      n_data = i_right;
            olist_pkg::OP_COLLAPSE: n_data = w_beyond ? i_right : r_data;
            default:                n_data = r_data;
        endcase
    end

    // Entry storage; its contents mean nothing until written.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- src/olist_ctrl.sv -----
// ============================================================================
// olist_ctrl: sequencer of the ordered list engine
// Accepts actions, keeps the entry count, steps the cell chain through its
// rotation sweeps and drives the registered result channel.
// ============================================================================
module olist_ctrl #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [olist_pkg::ACT_W-1:0]           i_action,
    input  logic signed [olist_pkg::PORT_W-1:0]   i_item_value,
    input  logic [DATA_WIDTH-1:0]                 i_head_data,
    input  logic [DATA_WIDTH-1:0]                 i_tail_data,
    output logic [DATA_WIDTH-1:0]                 o_head_in,
    output olist_pkg::t_cell_ctl                  o_ctl,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [olist_pkg::PORT_W-1:0]   o_element_value,
    output logic signed [olist_pkg::IDX_W-1:0]    o_found_index,
    output logic [olist_pkg::STAT_W-1:0]          o_status,
    output logic                                  o_last
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEPTH - 1);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_SWEEP    = 2'd1;
    localparam logic [1:0] S_COLLAPSE = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic [STEP_W-1:0]                 r_step, n_step;
    logic                              r_hit, n_hit;
    logic [olist_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [olist_pkg::ACT_W-1:0]       r_act, n_act;
    logic [DATA_WIDTH-1:0]             r_value, n_value;

    logic                              r_out_valid;
    logic [olist_pkg::PORT_W-1:0]      r_out_elem;
    logic [olist_pkg::IDX_W-1:0]       r_out_idx;
    logic [olist_pkg::STAT_W-1:0]      r_out_stat;
    logic                              r_out_last;

    logic                              w_out_free;
    logic                              w_in_acc;
    logic signed [DATA_WIDTH-1:0]      w_ins_value;
    logic                              w_in_range;
    logic                              w_hit_now;
    logic                              w_last_step;
    logic                              w_emit;
    logic [olist_pkg::PORT_W-1:0]      w_elem;
    logic [olist_pkg::IDX_W-1:0]       w_idx;
    logic [olist_pkg::STAT_W-1:0]      w_stat;
    logic                              w_last;

    // The result register can take a new result this cycle.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && w_out_free);
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // Input value sign-extended or cut to the entry width.
    assign w_ins_value = DATA_WIDTH'(i_item_value);

    // Sweep bookkeeping: the head cell holds position r_step of the list.
    assign w_in_range  = (CNT_W'(r_step) < r_count);
    assign w_hit_now   = w_in_range && !r_hit && (i_head_data == r_value);
    assign w_last_step = (r_step == LAST_STEP);

    // New head entry: the input on insert, the tail cell on rotate right.
    assign o_head_in = (r_state == S_IDLE) ? DATA_WIDTH'(w_ins_value) : i_tail_data;

    // Sequencer and cell commands.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_step   = r_step;
        n_hit    = r_hit;
        n_pos    = r_pos;
        n_act    = r_act;
        n_value  = r_value;
        o_ctl.op = olist_pkg::OP_HOLD;
        o_ctl.k  = r_pos;
        w_emit   = 1'b0;
        w_elem   = '0;
        w_idx    = '0;
        w_stat   = olist_pkg::ST_OK;
        w_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_act   = i_action;
                    n_value = DATA_WIDTH'(w_ins_value);
                    n_step  = '0;
                    n_hit   = 1'b0;
                    unique case (i_action)
                        olist_pkg::ACT_INSERT: begin
                            w_emit = 1'b1;
                            if (r_count == FULL_CNT) begin
                                w_stat = olist_pkg::ST_FULL;
                            end else begin
                                o_ctl.op = olist_pkg::OP_SHR;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        olist_pkg::ACT_ERASE: begin
                            if (r_count == '0) begin
                                w_emit = 1'b1;
                                w_stat = olist_pkg::ST_NOTFOUND;
                            end else begin
                                n_state = S_SWEEP;
                            end
                        end
                        olist_pkg::ACT_SEARCH: begin
                            if (r_count == '0) begin
                                w_emit = 1'b1;
                                w_idx  = olist_pkg::FOUND_NONE;
                                w_stat = olist_pkg::ST_NOTFOUND;
                            end else begin
                                n_state = S_SWEEP;
                            end
                        end
                        olist_pkg::ACT_DUMP_FWD,
                        olist_pkg::ACT_DUMP_REV: begin
                            if (r_count == '0) begin
                                w_emit = 1'b1;
                                w_stat = olist_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_SWEEP;
                            end
                        end
                        default: begin
                            // Unknown actions are taken and dropped.
                        end
                    endcase
                end
            end

            S_SWEEP: begin
                if (w_out_free) begin
                    n_step = w_last_step ? '0 : r_step + 1'b1;
                    if (r_act == olist_pkg::ACT_DUMP_REV) begin
                        // Rotate right; the tail cell shows positions downwards.
                        o_ctl.op = olist_pkg::OP_SHR;
                        if (CNT_W'(r_step) >= FULL_CNT - r_count) begin
                            w_emit = 1'b1;
                            w_elem = olist_pkg::PORT_W'(signed'(i_tail_data));
                            w_last = w_last_step;
                        end
                    end else begin
                        // Rotate left; the head cell shows positions upwards.
                        o_ctl.op = olist_pkg::OP_SHL;
                        if (r_act == olist_pkg::ACT_DUMP_FWD) begin
                            if (w_in_range) begin
                                w_emit = 1'b1;
                                w_elem = olist_pkg::PORT_W'(signed'(i_head_data));
                                w_last = (CNT_W'(r_step) == r_count - 1'b1);
                            end
                        end else if (w_hit_now) begin
                            n_hit = 1'b1;
                            n_pos = olist_pkg::POS_W'(r_step);
                        end
                    end

                    if (w_last_step) begin
                        n_state = S_IDLE;
                        if (r_act == olist_pkg::ACT_SEARCH) begin
                            w_emit = 1'b1;
                            if (r_hit || w_hit_now) begin
                                w_idx = olist_pkg::IDX_W'(n_pos);
                            end else begin
                                w_idx  = olist_pkg::FOUND_NONE;
                                w_stat = olist_pkg::ST_NOTFOUND;
                            end
                        end else if (r_act == olist_pkg::ACT_ERASE) begin
                            if (r_hit || w_hit_now) begin
                                n_state = S_COLLAPSE;
                            end else begin
                                w_emit = 1'b1;
                                w_stat = olist_pkg::ST_NOTFOUND;
                            end
                        end
                    end
                end
            end

            S_COLLAPSE: begin
                if (w_out_free) begin
                    o_ctl.op = olist_pkg::OP_COLLAPSE;
                    n_count  = r_count - 1'b1;
                    w_emit   = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_hit   <= n_hit;
        end
    end

    // Operation payload registers.
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_act   <= n_act;
        r_value <= n_value;
    end

    // Result register: loaded on a new result, emptied after a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_elem <= w_elem;
            r_out_idx  <= w_idx;
            r_out_stat <= w_stat;
            r_out_last <= w_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_element_value = signed'(r_out_elem);
    assign o_found_index   = signed'(r_out_idx);
    assign o_status        = r_out_stat;
    assign o_last          = r_out_last;

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond capacity");

    // A new input transfer is never taken while an operation is under way.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while busy");

    // A completed collapse removes exactly one entry.
    a_collapse_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COLLAPSE && w_out_free) |=> (r_count == $past(r_count) - 1'b1))
        else $error("collapse did not remove one entry");

    // Only dump entries can be followed by further results of the same transfer.
    a_nonlast_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_status == olist_pkg::ST_OK && o_found_index == '0))
        else $error("non-final result not from a dump");

    // A sweep always starts from the head position.
    a_sweep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_SWEEP) |=> (r_step == '0))
        else $error("sweep did not start at the head");

endmodule

// ----- src/ordered_list_engine_top.sv -----
// ============================================================================
// ordered_list_engine_top: bounded ordered list store
// Holds up to DEPTH entries in a chain of cells and serves insert at head,
// erase, search and forward and reverse dumps over valid/stall channels.
// ============================================================================
// The list lives in a ring of DEPTH cells, one entry per cell, with the head
// in cell 0. An insert that has room shifts the whole chain by one cell, and
// any action on an empty store ends without a sweep. Search, erase and both
// dumps otherwise rotate the ring one cell per clock, while the result
// register is free, through a full turn so that the entries come back into
// place; a dump gives one result per clock as entries pass the head or tail
// cell, and an erase that finds its value then closes the gap with a collapse
// step. No new input transfer is taken until such an operation is over.
// Results leave through a single register: while it holds a stalled result
// the rotation pauses and no new input transfer is taken, so result stalls
// lengthen an operation. No clearing pass follows reset; only the first
// entry-count cells are read.
module ordered_list_engine_top #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [olist_pkg::ACT_W-1:0]          i_action,
    input  logic signed [olist_pkg::PORT_W-1:0]  i_item_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [olist_pkg::PORT_W-1:0]  o_element_value,
    output logic signed [olist_pkg::IDX_W-1:0]   o_found_index,
    output logic [olist_pkg::STAT_W-1:0]         o_status,
    output logic                                 o_last
);

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_head_in;
    olist_pkg::t_cell_ctl  w_ctl;

    // Sequencer.
    olist_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_item_value    (i_item_value),
        .i_head_data     (w_data[0]),
        .i_tail_data     (w_data[DEPTH-1]),
        .o_head_in       (w_head_in),
        .o_ctl           (w_ctl),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_element_value (o_element_value),
        .o_found_index   (o_found_index),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    // Ring of cells; the head takes new entries, the tail wraps to the head.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = w_head_in;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_data[0];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        olist_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

endmodule

// ----- dv/olist_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// olist_checker: result predictor and scoreboard for the ordered list engine
// Watches the input and result channels, keeps its own copy of the list,
// works out the results that each accepted transfer must cause and compares
// every accepted result, field by field, with the oldest one outstanding.
// ============================================================================
module olist_checker #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [olist_pkg::ACT_W-1:0]          i_action,
    input  logic signed [olist_pkg::PORT_W-1:0]  i_item_value,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [olist_pkg::PORT_W-1:0]  i_element_value,
    input  logic signed [olist_pkg::IDX_W-1:0]   i_found_index,
    input  logic [olist_pkg::STAT_W-1:0]         i_status,
    input  logic                                 i_last,
    output int                                   o_mismatch_count,
    output int                                   o_results_pending,
    output int                                   o_results_checked
);

    // One result as it leaves the block.
    typedef struct packed {
        logic signed [olist_pkg::PORT_W-1:0] element_value;
        logic signed [olist_pkg::IDX_W-1:0]  found_index;
        logic [olist_pkg::STAT_W-1:0]        status;
        logic                                last;
    } t_list_result;

    // Shadow copy of the list, head at position 0.
    logic signed [DATA_WIDTH-1:0] shadow_entries [DEPTH];
    int                           shadow_count;

    // Results still owed by the block, oldest first.
    t_list_result owed_results [$];

    int mismatch_total = 0;
    int checked_total  = 0;
    int pending_total  = 0;

    assign o_mismatch_count  = mismatch_total;
    assign o_results_pending = pending_total;
    assign o_results_checked = checked_total;

    // Append one predicted result behind those already owed.
    function automatic void queue_result(input t_list_result res);
        owed_results.insert(owed_results.size(), res);
    endfunction

    // Apply one accepted action to the shadow list and queue its results.
    function automatic void apply_list_action(
        input logic [olist_pkg::ACT_W-1:0]         act,
        input logic signed [olist_pkg::PORT_W-1:0] value);
        logic signed [DATA_WIDTH-1:0]        key;
        logic signed [olist_pkg::PORT_W-1:0] shown;
        t_list_result                        res;
        int                                  hit;
        int                                  pos;
        int                                  i;

        // The value is sign-extended or cut to the entry width before use.
        key        = value;
        res        = '0;
        res.last   = 1'b1;
        res.status = olist_pkg::ST_OK;
        hit        = -1;
        for (i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_entries[i] == key) begin
                hit = i;
            end
        end

        case (act)
            olist_pkg::ACT_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = olist_pkg::ST_FULL;
                end else begin
                    for (i = shadow_count; i > 0; i--) begin
                        shadow_entries[i] = shadow_entries[i-1];
                    end
                    shadow_entries[0] = key;
                    shadow_count++;
                end
            end
            olist_pkg::ACT_ERASE: begin
                if (hit < 0) begin
                    res.status = olist_pkg::ST_NOTFOUND;
                end else begin
                    for (i = hit; i < shadow_count - 1; i++) begin
                        shadow_entries[i] = shadow_entries[i+1];
                    end
                    shadow_count--;
                end
            end
            olist_pkg::ACT_SEARCH: begin
                if (hit < 0) begin
                    res.status      = olist_pkg::ST_NOTFOUND;
                    res.found_index = olist_pkg::FOUND_NONE;
                end else begin
                    res.found_index = olist_pkg::IDX_W'(hit);
                end
            end
            olist_pkg::ACT_DUMP_FWD, olist_pkg::ACT_DUMP_REV: begin
                if (shadow_count == 0) begin
                    res.status = olist_pkg::ST_EMPTY;
                end else begin
                    // One result per entry; only the final one is marked.
                    for (i = 0; i < shadow_count; i++) begin
                        pos = (act == olist_pkg::ACT_DUMP_FWD) ? i : shadow_count - 1 - i;
                        shown             = shadow_entries[pos];
                        res.element_value = shown;
                        res.last          = (i == shadow_count - 1);
                        queue_result(res);
                    end
                    return;
                end
            end
            default: begin
                // Unused action codes are dropped without a result.
                return;
            end
        endcase
        queue_result(res);
    endfunction

    function automatic void flag_mismatch(input string field,
                                          input logic [olist_pkg::PORT_W-1:0] want,
                                          input logic [olist_pkg::PORT_W-1:0] got);
        mismatch_total++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // Compare one accepted result with the oldest outstanding one.
    function automatic void check_result();
        t_list_result want;

        checked_total++;
        if (owed_results.size() == 0) begin
            mismatch_total++;
            $display("%0t: result with none outstanding, expected none, actual %0h %0h %0h %0h",
                     $time, i_element_value, i_found_index, i_status, i_last);
            return;
        end
        want = owed_results.pop_front();
        if (i_element_value !== want.element_value) begin
            flag_mismatch("element_value", want.element_value, i_element_value);
        end
        if (i_found_index !== want.found_index) begin
            flag_mismatch("found_index", olist_pkg::PORT_W'(want.found_index),
                          olist_pkg::PORT_W'(i_found_index));
        end
        if (i_status !== want.status) begin
            flag_mismatch("status", olist_pkg::PORT_W'(want.status),
                          olist_pkg::PORT_W'(i_status));
        end
        if (i_last !== want.last) begin
            flag_mismatch("last", olist_pkg::PORT_W'(want.last), olist_pkg::PORT_W'(i_last));
        end
    endfunction

    // Results are taken before the new transfer of the same edge; any
    // result at that edge belongs to an earlier transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            owed_results.delete();
            pending_total <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_in_valid && !i_in_stall) begin
                apply_list_action(i_action, i_item_value);
            end
            pending_total <= owed_results.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench top for the ordered list engine
// Drives directed and random insert, erase, search and dump transfers with
// bursty input pacing and a patterned result stall; a separate checker
// predicts and compares every result, and this module gives the verdict.
// ============================================================================
module tb;

    localparam int LIST_DEPTH   = 64;
    localparam int LIST_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 170;

    // Action codes that the block drops without a result.
    localparam logic [olist_pkg::ACT_W-1:0] ACT_FIRST_UNUSED = olist_pkg::ACT_DUMP_REV + 3'd1;
    localparam logic [olist_pkg::ACT_W-1:0] ACT_LAST_CODE    = '1;

    logic                                clk        = 1'b0;
    logic                                rst_n      = 1'b0;
    logic                                in_valid   = 1'b0;
    logic                                in_stall;
    logic [olist_pkg::ACT_W-1:0]         action     = olist_pkg::ACT_INSERT;
    logic signed [olist_pkg::PORT_W-1:0] item_value = '0;
    logic                                out_valid;
    logic                                out_stall  = 1'b0;
    logic signed [olist_pkg::PORT_W-1:0] element_value;
    logic signed [olist_pkg::IDX_W-1:0]  found_index;
    logic [olist_pkg::STAT_W-1:0]        status;
    logic                                last;

    int mismatch_count;
    int results_pending;
    int results_checked;

    // Transfer tallies for the closing summary.
    int inserts_sent = 0;
    int erases_sent  = 0;
    int searches_sent = 0;
    int dumps_sent   = 0;
    int ignored_sent = 0;

    // Sender pacing state.
    int burst_left = 0;

    // Values inserted lately, so that erases and searches often hit.
    logic signed [olist_pkg::PORT_W-1:0] recent_values [$];

    ordered_list_engine_top #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (LIST_WIDTH)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_action        (action),
        .i_item_value    (item_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_element_value (element_value),
        .o_found_index   (found_index),
        .o_status        (status),
        .o_last          (last)
    );

    olist_checker #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (LIST_WIDTH)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_action          (action),
        .i_item_value      (item_value),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_element_value   (element_value),
        .i_found_index     (found_index),
        .i_status          (status),
        .i_last            (last),
        .o_mismatch_count  (mismatch_count),
        .o_results_pending (results_pending),
        .o_results_checked (results_checked)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #12_000_000;
        $display("[ordered_list_engine_top] ERROR");
        $finish;
    end

    // Result stall: stretches of no stall, light random stall and heavy random stall.
    initial begin
        int stall_mode;
        int stretch;
        forever begin
            stall_mode = $urandom_range(0, 2);
            stretch    = $urandom_range(10, 80);
            repeat (stretch) begin
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 2) == 0);
                    default: out_stall <= ($urandom_range(0, 5) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic logic signed [olist_pkg::PORT_W-1:0] corner_value();
        case ($urandom_range(0, 6))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4:       return 32'sh0000_0001;
            5:       return 32'sh5555_5555;
            default: return 32'shAAAA_AAAA;
        endcase
    endfunction

    // Often values that may be in the list, else corners or fully random values.
    function automatic logic signed [olist_pkg::PORT_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4 && recent_values.size() > 0) begin
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
        end
        if (roll < 7) begin
            return corner_value();
        end
        return $urandom;
    endfunction

    // Keep a bounded window of the values inserted most recently.
    function automatic void remember_value(input logic signed [olist_pkg::PORT_W-1:0] value);
        recent_values.insert(recent_values.size(), value);
        if (recent_values.size() > 96) recent_values.pop_front();
    endfunction

    function automatic logic [olist_pkg::ACT_W-1:0] unused_action(
        input logic [olist_pkg::ACT_W-1:0] first_unused);
        return olist_pkg::ACT_W'($urandom_range(first_unused, ACT_LAST_CODE));
    endfunction

    function automatic logic [olist_pkg::ACT_W-1:0] pick_action();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return olist_pkg::ACT_INSERT;
        if (roll < 50) return olist_pkg::ACT_ERASE;
        if (roll < 75) return olist_pkg::ACT_SEARCH;
        if (roll < 85) return olist_pkg::ACT_DUMP_FWD;
        if (roll < 95) return olist_pkg::ACT_DUMP_REV;
        return unused_action(ACT_FIRST_UNUSED);
    endfunction

    function automatic logic [olist_pkg::ACT_W-1:0] pick_dump();
        if ($urandom_range(0, 1) != 0) return olist_pkg::ACT_DUMP_FWD;
        return olist_pkg::ACT_DUMP_REV;
    endfunction

    function automatic int counted_items();
        return inserts_sent + erases_sent + searches_sent + dumps_sent;
    endfunction

    // Present one transfer, hold it until accepted, then pace the next one.
    task automatic send_item(input logic [olist_pkg::ACT_W-1:0] act,
                             input logic signed [olist_pkg::PORT_W-1:0] value);
        int gap;
        in_valid   <= 1'b1;
        action     <= act;
        item_value <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);

        case (act)
            olist_pkg::ACT_INSERT: begin
                inserts_sent++;
                remember_value(value);
            end
            olist_pkg::ACT_ERASE:     erases_sent++;
            olist_pkg::ACT_SEARCH:    searches_sent++;
            olist_pkg::ACT_DUMP_FWD,
            olist_pkg::ACT_DUMP_REV:  dumps_sent++;
            default:                  ignored_sent++;
        endcase

        // Bursts of back-to-back transfers separated by random gaps.
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 6);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Hold the input back until every outstanding result has come out.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
    endtask

    initial begin
        int episode;
        int span;
        int n;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, extremes, duplicates, misses, unused codes.
        send_item(olist_pkg::ACT_DUMP_FWD, 32'sd0);
        send_item(olist_pkg::ACT_DUMP_REV, -32'sd1);
        send_item(olist_pkg::ACT_SEARCH, 32'sd5);
        send_item(olist_pkg::ACT_ERASE, 32'sd5);
        send_item(ACT_FIRST_UNUSED, 32'sd7);
        send_item(olist_pkg::ACT_INSERT, 32'sh8000_0000);
        send_item(olist_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
        send_item(olist_pkg::ACT_INSERT, 32'sd0);
        send_item(olist_pkg::ACT_INSERT, -32'sd1);
        send_item(olist_pkg::ACT_INSERT, 32'sd0);
        send_item(olist_pkg::ACT_SEARCH, 32'sd0);
        send_item(olist_pkg::ACT_SEARCH, 32'sh8000_0000);
        send_item(olist_pkg::ACT_SEARCH, 32'sd12345);
        send_item(olist_pkg::ACT_DUMP_FWD, 32'sd0);
        send_item(olist_pkg::ACT_DUMP_REV, 32'sd0);
        send_item(olist_pkg::ACT_ERASE, 32'sd0);
        send_item(olist_pkg::ACT_ERASE, 32'sd999);
        send_item(olist_pkg::ACT_SEARCH, 32'sd0);
        send_item(ACT_LAST_CODE, -32'sd1);
        send_item(olist_pkg::ACT_ERASE, 32'sh7FFF_FFFF);
        send_item(olist_pkg::ACT_DUMP_FWD, 32'sd0);
        send_item(olist_pkg::ACT_ERASE, -32'sd1);
        send_item(olist_pkg::ACT_ERASE, 32'sd0);
        send_item(olist_pkg::ACT_ERASE, 32'sh8000_0000);
        send_item(olist_pkg::ACT_DUMP_REV, 32'sd0);

        // Let everything drain before the random part.
        wait_for_results();

        // Fill past capacity, then dump the full list both ways.
        repeat (LIST_DEPTH + 6) send_item(olist_pkg::ACT_INSERT, pick_value());
        send_item(olist_pkg::ACT_SEARCH, pick_value());
        send_item(olist_pkg::ACT_DUMP_FWD, $urandom);
        send_item(olist_pkg::ACT_DUMP_REV, $urandom);

        // Random episodes: mixed traffic, fills, drains and full pauses.
        n = counted_items();
        while (counted_items() - n < RANDOM_ITEMS) begin
            episode = $urandom_range(0, 9);
            if (episode <= 4) begin
                span = $urandom_range(8, 25);
                repeat (span) send_item(pick_action(), pick_value());
            end else if (episode <= 6) begin
                span = $urandom_range(20, 60);
                repeat (span) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_item(olist_pkg::ACT_SEARCH, pick_value());
                    end else begin
                        send_item(olist_pkg::ACT_INSERT, pick_value());
                    end
                end
                send_item(pick_dump(), $urandom);
            end else if (episode <= 8) begin
                span = $urandom_range(20, 50);
                repeat (span) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(olist_pkg::ACT_ERASE, $urandom);
                    end else begin
                        send_item(olist_pkg::ACT_ERASE, pick_value());
                    end
                end
                send_item(pick_dump(), $urandom);
            end else begin
                wait_for_results();
            end
        end

        // Wait out the outstanding results, then the block's own latency.
        wait_for_results();
        repeat (2 * LIST_DEPTH + 16) @(posedge clk);

        $display("Sent %0d inserts, %0d erases, %0d searches and %0d dumps,",
                 inserts_sent, erases_sent, searches_sent, dumps_sent);
        $display("plus %0d unused codes; checked %0d results from empty to full and back.",
                 ignored_sent, results_checked);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("[ordered_list_engine_top] OK");
        end else begin
            $display("[ordered_list_engine_top] ERROR");
        end
        $finish;
    end

endmodule
